// ===== sv/ccfd_pkg.sv =====
// package for the crc checked frame deframer
// shared constants and types, no dependencies
package ccfd_pkg;
  localparam int unsigned BufDepth = 512;
  localparam int unsigned AddrW = $clog2(BufDepth);
  localparam int unsigned CntW = 10;
  localparam int unsigned FrameOverhead = 7;
  localparam int unsigned QDepth = 4;

  localparam logic ActAppend = 1'b0;
  localparam logic ActClear = 1'b1;

  localparam logic [1:0] RegMarkFirst = 2'd0;
  localparam logic [1:0] RegMarkSecond = 2'd1;
  localparam logic [1:0] RegVersion = 2'd2;

  // one queued command between front and back
  typedef struct packed {
    logic       clear;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] mark_first;
    logic [7:0] mark_second;
    logic [7:0] version;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction
endpackage

// ===== sv/crc_checked_frame_deframer.sv =====
// crc checked frame deframer top level: front queue plus search/emit back end
// each append command starts a check and search of the buffer; the back end takes no new
// command until done; a good frame of total=7+len bytes leaves as beats of up to 8 bytes
// the single ram read port and serial crc walk set the pace; rescans and stalls add more
// reset (rst_ni low, async) empties buffer and queue and loads default marks
// depends on ccfd_pkg, ccfd_front, ccfd_back, ccfd_ram
module crc_checked_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] beat_data_o,
  output logic [3:0]  beat_bytes_o,
  output logic        frame_last_o
);
  import ccfd_pkg::*;
  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // front: takes transactions into a short command queue
  ccfd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .data_byte_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  // back: buffer, search and beat output register
  ccfd_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid_o, .out_ready_i, .beat_data_o, .beat_bytes_o, .frame_last_o
  );
endmodule

// ===== sv/ccfd_ram.sv =====
// generic ram with one write port and one read port, registered read
// no dependencies
module ccfd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/ccfd_front.sv =====
// front end: accepts transactions and config writes, queues commands
// depends on ccfd_pkg
module ccfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           action_i,
  input  logic [7:0]     data_byte_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  output ccfd_pkg::cfg_t cfg_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output ccfd_pkg::cmd_t cmd_o
);
  import ccfd_pkg::*;
  localparam int unsigned PW = $clog2(QDepth);
  cmd_t q_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0] cnt_q;
  cfg_t cfg_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != (PW+1)'(QDepth));
  assign push = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_q[rp_q];
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= '{clear: (action_i == ActClear), data: data_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
      cfg_q <= '{mark_first: 8'hAA, mark_second: 8'h55, version: 8'h01};
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMarkFirst:  cfg_q.mark_first <= cfg_data_i;
          RegMarkSecond: cfg_q.mark_second <= cfg_data_i;
          RegVersion:    cfg_q.version <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sv/ccfd_back.sv =====
// back end: resync buffer as circular ram, frame search, crc and beat output
// depends on ccfd_pkg and ccfd_ram
module ccfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ccfd_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  ccfd_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [63:0]    beat_data_o,
  output logic [3:0]     beat_bytes_o,
  output logic           frame_last_o
);
  import ccfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_SCAN_W, S_HDR, S_HDR_W, S_CRC, S_CRC_W,
    S_EMIT, S_EMIT_W, S_OUT
  } state_e;

  state_e st_q;
  // buffer is a window [head, head+cnt) of a circular ram
  logic [AddrW-1:0] head_q, raddr;
  logic [CntW-1:0]  cnt_q, pos_q, idx_q, total_q;
  logic [7:0]       rdata, prev_q;
  logic [15:0]      crc_q, got_q;
  logic             we;
  logic [63:0]      word_q;
  logic [3:0]       nb_q;
  logic             obusy_q;

  // a byte arriving on a full buffer is dropped
  assign we = (st_q == S_IDLE) && cmd_valid_i && !cmd_i.clear && !obusy_q &&
              (cnt_q < CntW'(BufDepth));
  assign cmd_ready_o = (st_q == S_IDLE) && !obusy_q;
  assign raddr = head_q + AddrW'(idx_q);

  ccfd_ram #(.Width(8), .Depth(BufDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(head_q + AddrW'(cnt_q)), .wdata_i(cmd_i.data),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign out_valid_o = obusy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      head_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
      idx_q <= '0;
      total_q <= '0;
      prev_q <= '0;
      crc_q <= '0;
      got_q <= '0;
      word_q <= '0;
      nb_q <= '0;
      obusy_q <= 1'b0;
      beat_data_o <= '0;
      beat_bytes_o <= '0;
      frame_last_o <= 1'b0;
    end else begin
      if (obusy_q && out_ready_i) obusy_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i && !obusy_q) begin
            if (cmd_i.clear) begin
              cnt_q <= '0;
            end else begin
              if (cnt_q < CntW'(BufDepth)) cnt_q <= cnt_q + 1'b1;
              st_q <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (cnt_q >= CntW'(FrameOverhead)) begin
            pos_q <= '0;
            idx_q <= '0;
            st_q <= S_SCAN_W;
          end else begin
            st_q <= S_IDLE;
          end
        end
        S_SCAN_W: begin
          idx_q <= idx_q + 1'b1;
          st_q <= S_SCAN;
        end
        S_SCAN: begin
          // rdata is byte idx-1; compare pair (idx-2, idx-1)
          prev_q <= rdata;
          if (idx_q >= 2 && prev_q == cfg_i.mark_first && rdata == cfg_i.mark_second) begin
            pos_q <= idx_q - 2'd2;
            if (cnt_q - (idx_q - 2'd2) < CntW'(FrameOverhead)) begin
              head_q <= head_q + AddrW'(idx_q - 2'd2);
              cnt_q <= cnt_q - (idx_q - 2'd2);
              st_q <= S_IDLE;
            end else begin
              idx_q <= idx_q;
              st_q <= S_HDR_W;
            end
          end else if (idx_q == cnt_q) begin
            // no mark: keep only a trailing first-mark byte
            if (rdata == cfg_i.mark_first) begin
              head_q <= head_q + AddrW'(cnt_q - 1'b1);
              cnt_q <= CntW'(1);
            end else begin
              cnt_q <= '0;
            end
            st_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_HDR_W: begin
          // idx points at version byte (pos+2)
          idx_q <= idx_q + 1'b1;
          st_q <= S_HDR;
        end
        S_HDR: begin
          if (idx_q == pos_q + 2'd3) begin
            if (rdata != cfg_i.version) begin
              head_q <= head_q + AddrW'(pos_q + 1'b1);
              cnt_q <= cnt_q - pos_q - 1'b1;
              st_q <= S_CHECK;
            end else begin
              crc_q <= crc_byte(16'hFFFF, rdata);
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            total_q <= CntW'(FrameOverhead) + CntW'(rdata);
            if (cnt_q - pos_q < CntW'(FrameOverhead) + CntW'(rdata)) begin
              head_q <= head_q + AddrW'(pos_q);
              cnt_q <= cnt_q - pos_q;
              st_q <= S_IDLE;
            end else begin
              crc_q <= crc_byte(crc_q, rdata);
              idx_q <= idx_q + 1'b1;
              st_q <= S_CRC;
            end
          end
        end
        S_CRC: begin
          // rdata is byte idx-1; crc over pos+4 .. pos+total-3
          if (idx_q - 1'b1 <= pos_q + total_q - 2'd3) begin
            crc_q <= crc_byte(crc_q, rdata);
          end else if (idx_q - 1'b1 == pos_q + total_q - 2'd2) begin
            got_q[7:0] <= rdata;
          end else begin
            got_q[15:8] <= rdata;
          end
          if (idx_q - 1'b1 == pos_q + total_q - 1'b1) begin
            st_q <= S_CRC_W;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_CRC_W: begin
          if (crc_q != got_q) begin
            head_q <= head_q + AddrW'(pos_q + 1'b1);
            cnt_q <= cnt_q - pos_q - 1'b1;
            st_q <= S_CHECK;
          end else begin
            idx_q <= pos_q;
            word_q <= '0;
            nb_q <= '0;
            st_q <= S_EMIT_W;
          end
        end
        S_EMIT_W: begin
          idx_q <= idx_q + 1'b1;
          st_q <= S_EMIT;
        end
        S_EMIT: begin
          word_q[nb_q[2:0]*8 +: 8] <= rdata;
          nb_q <= nb_q + 1'b1;
          if (nb_q == 4'd7 || idx_q == pos_q + total_q) begin
            st_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (!obusy_q) begin
            obusy_q <= 1'b1;
            beat_data_o <= word_q;
            beat_bytes_o <= nb_q;
            frame_last_o <= (idx_q == pos_q + total_q);
            word_q <= '0;
            nb_q <= '0;
            if (idx_q == pos_q + total_q) begin
              head_q <= head_q + AddrW'(pos_q + total_q);
              cnt_q <= cnt_q - pos_q - total_q;
              st_q <= S_CHECK;
            end else begin
              st_q <= S_EMIT_W;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
